### hw/rtl/text_glyph_renderer_assert.svh
// Assertion macros used by the checker of the glyph renderer.
`ifndef TEXT_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_GLYPH_RENDERER_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define TGR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define TGR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tgr_pkg.sv
// Types, operation codes and the 5x7 font table of the glyph renderer.
package tgr_pkg;

  typedef logic [15:0] color_t;
  typedef logic [9:0]  coord_t;
  typedef logic [7:0]  code_t;
  typedef logic [1:0]  op_t;
  typedef logic [5:0]  cell_t;

  // Operation codes.
  localparam op_t OP_DRAW_AT     = 2'd0;
  localparam op_t OP_DRAW_CURSOR = 2'd1;
  localparam op_t OP_SET_CURSOR  = 2'd2;

  // Font geometry.
  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_W     = 5;
  localparam int GLYPH_H     = 7;
  localparam int ROM_DEPTH   = GLYPH_COUNT * GLYPH_W;
  localparam int ROM_AW      = $clog2(ROM_DEPTH);
  localparam int GLYPH_IW    = $clog2(GLYPH_COUNT);

  localparam logic [2:0] LAST_COL = 3'(GLYPH_W - 1);
  localparam logic [2:0] LAST_ROW = 3'(GLYPH_H - 1);

  // Printable code range covered by the font.
  localparam code_t FIRST_CODE = 8'd32;
  localparam code_t LAST_CODE  = 8'(32 + GLYPH_COUNT - 1);

  typedef logic [ROM_AW-1:0] rom_addr_t;

  // Read request to the font memory.
  typedef struct packed {
    logic      en;
    rom_addr_t addr;
  } rom_req_t;

  // Five column bytes per glyph; bit k of a column is glyph row k.
  localparam logic [7:0] GLYPH_ROM [0:ROM_DEPTH-1] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
    8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
    8'h12,8'h2A,8'h7F,8'h2A,8'h24, 8'h62,8'h64,8'h08,8'h13,8'h23,
    8'h50,8'h22,8'h55,8'h49,8'h36, 8'h00,8'h05,8'h03,8'h00,8'h00,
    8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h00,8'h1C,8'h22,8'h41,8'h00,
    8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h00,8'h30,8'h50,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h60,8'h60,8'h00,8'h00, 8'h02,8'h04,8'h08,8'h10,8'h20,
    8'h3E,8'h45,8'h49,8'h51,8'h3E, 8'h00,8'h40,8'h7F,8'h42,8'h00,
    8'h46,8'h49,8'h51,8'h61,8'h42, 8'h31,8'h4B,8'h45,8'h41,8'h21,
    8'h10,8'h7F,8'h12,8'h14,8'h18, 8'h39,8'h45,8'h45,8'h45,8'h27,
    8'h30,8'h49,8'h49,8'h4A,8'h3C, 8'h03,8'h05,8'h09,8'h71,8'h01,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h1E,8'h29,8'h49,8'h49,8'h06,
    8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h00,8'h36,8'h56,8'h00,
    8'h41,8'h22,8'h14,8'h08,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h00,8'h08,8'h14,8'h22,8'h41, 8'h06,8'h09,8'h51,8'h01,8'h02,
    8'h3E,8'h41,8'h79,8'h49,8'h32, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
    8'h36,8'h49,8'h49,8'h49,8'h7F, 8'h22,8'h41,8'h41,8'h41,8'h3E,
    8'h1C,8'h22,8'h41,8'h41,8'h7F, 8'h41,8'h49,8'h49,8'h49,8'h7F,
    8'h01,8'h01,8'h09,8'h09,8'h7F, 8'h32,8'h51,8'h41,8'h41,8'h3E,
    8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h01,8'h3F,8'h41,8'h40,8'h20, 8'h41,8'h22,8'h14,8'h08,8'h7F,
    8'h40,8'h40,8'h40,8'h40,8'h7F, 8'h7F,8'h02,8'h04,8'h02,8'h7F,
    8'h7F,8'h10,8'h08,8'h04,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h06,8'h09,8'h09,8'h09,8'h7F, 8'h5E,8'h21,8'h51,8'h41,8'h3E,
    8'h46,8'h29,8'h19,8'h09,8'h7F, 8'h31,8'h49,8'h49,8'h49,8'h46,
    8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F,
    8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03,
    8'h43,8'h45,8'h49,8'h51,8'h61, 8'h41,8'h41,8'h7F,8'h00,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02, 8'h00,8'h00,8'h7F,8'h41,8'h41,
    8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
    8'h00,8'h04,8'h02,8'h01,8'h00, 8'h78,8'h54,8'h54,8'h54,8'h20,
    8'h38,8'h44,8'h44,8'h48,8'h7F, 8'h20,8'h44,8'h44,8'h44,8'h38,
    8'h7F,8'h44,8'h44,8'h48,8'h38, 8'h18,8'h54,8'h54,8'h54,8'h38,
    8'h02,8'h01,8'h09,8'h7E,8'h08, 8'h3C,8'h54,8'h54,8'h14,8'h08,
    8'h78,8'h04,8'h04,8'h08,8'h7F, 8'h00,8'h40,8'h7D,8'h44,8'h00,
    8'h00,8'h3D,8'h44,8'h40,8'h20, 8'h44,8'h28,8'h10,8'h7F,8'h00,
    8'h00,8'h40,8'h7F,8'h41,8'h00, 8'h78,8'h04,8'h18,8'h04,8'h7C,
    8'h78,8'h04,8'h04,8'h08,8'h7C, 8'h38,8'h44,8'h44,8'h44,8'h38,
    8'h08,8'h14,8'h14,8'h14,8'h7C, 8'h7C,8'h18,8'h14,8'h14,8'h08,
    8'h08,8'h04,8'h04,8'h08,8'h7C, 8'h20,8'h54,8'h54,8'h54,8'h48,
    8'h20,8'h40,8'h44,8'h3F,8'h04, 8'h7C,8'h20,8'h40,8'h40,8'h3C,
    8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h3C,8'h40,8'h30,8'h40,8'h3C,
    8'h44,8'h28,8'h10,8'h28,8'h44, 8'h3C,8'h50,8'h50,8'h50,8'h0C,
    8'h44,8'h4C,8'h54,8'h64,8'h44, 8'h00,8'h41,8'h36,8'h08,8'h00,
    8'h00,8'h00,8'h7F,8'h00,8'h00, 8'h00,8'h08,8'h36,8'h41,8'h00,
    8'h08,8'h1C,8'h2A,8'h08,8'h08, 8'h08,8'h08,8'h2A,8'h1C,8'h08
  };

endpackage

### hw/rtl/tgr_if.sv
// Valid/ready channels of the glyph renderer: character requests and pixels.
interface tgr_cmd_if;
  import tgr_pkg::*;

  logic   valid;
  logic   ready;
  op_t    operation;
  code_t  char_code;
  coord_t pos_x;
  coord_t pos_y;
  color_t ink_color;

  modport source (output valid, operation, char_code, pos_x, pos_y, ink_color,
                  input ready);
  modport sink   (input valid, operation, char_code, pos_x, pos_y, ink_color,
                  output ready);
endinterface

interface tgr_pix_if;
  import tgr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

### hw/rtl/tgr_glyph_rom.sv
// Synchronous font memory: one column byte per read, data registered for the next cycle.
module tgr_glyph_rom (
  input  logic              clk,
  input  tgr_pkg::rom_req_t req,
  output logic [7:0]        data
);
  import tgr_pkg::*;

  // Registered read; the data holds while no read is requested.
  always_ff @(posedge clk) begin
    if (req.en) begin
      data <= GLYPH_ROM[req.addr];
    end
  end

endmodule

### hw/rtl/text_glyph_renderer.sv
// Top level of the 5x7 text glyph renderer.
//
// Each draw request (draw at a pixel position, or draw at the text cursor and
// advance it) yields 35 pixels in row-major order, one per cycle while the
// pixel sink is ready, the 35th marked last. A new draw request is taken in the
// cycle its predecessor issues its last font read, so characters stream back to
// back; the single read port of the font memory supplies one column byte per
// pixel. A cursor-set request, or an undefined operation, emits nothing. The
// edge that takes a draw request loads the issue stage; the font read then fills
// the read stage, and the output register after it drives the pixel port. The
// background color may be written only while no character is in flight.
module text_glyph_renderer #(
  parameter int TEXT_COLUMNS = 40,
  parameter int TEXT_ROWS    = 40
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  tgr_pkg::color_t cfg_wdata,
  tgr_cmd_if.sink         cmd,
  tgr_pix_if.source       pix
);
  import tgr_pkg::*;

  localparam logic [6:0] COLS    = 7'(TEXT_COLUMNS);
  localparam logic [6:0] ROWS    = 7'(TEXT_ROWS);
  localparam coord_t     MAX_COL = 10'(TEXT_COLUMNS - 1);
  localparam coord_t     MAX_ROW = 10'(TEXT_ROWS - 1);

  color_t bg_color;
  cell_t  cur_col;
  cell_t  cur_row;
  cell_t  cur_col_next;
  cell_t  cur_row_next;

  // Issue stage.
  logic       s1_valid;
  rom_addr_t  s1_base;
  coord_t     s1_ox;
  coord_t     s1_oy;
  color_t     s1_ink;
  logic [2:0] s1_row;
  logic [2:0] s1_col;

  // Font read stage.
  logic       s2_valid;
  coord_t     s2_x;
  coord_t     s2_y;
  color_t     s2_ink;
  logic [2:0] s2_row;
  logic       s2_last;

  // Output register.
  logic   out_valid;
  coord_t out_x;
  coord_t out_y;
  color_t out_color;
  logic   out_last;

  logic                 advance;
  logic                 s1_end;
  logic                 cmd_acc;
  logic                 draw;
  logic                 code_ok;
  logic [GLYPH_IW-1:0]  glyph;
  rom_addr_t            glyph_base;
  coord_t               org_x;
  coord_t               org_y;
  logic [6:0]           col_inc;
  logic [6:0]           row_inc;
  rom_req_t             rom_req;
  logic [7:0]           rom_data;

  // The whole pixel pipeline moves when the output register can take a pixel.
  assign advance = !out_valid || pix.ready;
  assign s1_end  = (s1_row == LAST_ROW) && (s1_col == LAST_COL);

  // A request enters when the issue stage is free or hands off its last pixel.
  assign cmd.ready = !s1_valid || (s1_end && advance);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign draw      = cmd_acc &&
                     ((cmd.operation == OP_DRAW_AT) || (cmd.operation == OP_DRAW_CURSOR));

  // Glyph selection; codes outside the font draw as a space.
  assign code_ok    = (cmd.char_code >= FIRST_CODE) && (cmd.char_code <= LAST_CODE);
  assign glyph      = code_ok ? GLYPH_IW'(cmd.char_code - FIRST_CODE) : '0;
  assign glyph_base = ROM_AW'({glyph, 2'b00}) + ROM_AW'(glyph);

  // Origin: the given pixel position, or the cursor cell (column*6, row*8).
  always_comb begin
    if (cmd.operation == OP_DRAW_AT) begin
      org_x = cmd.pos_x;
      org_y = cmd.pos_y;
    end else begin
      org_x = 10'({cur_col, 2'b00}) + 10'({cur_col, 1'b0});
      org_y = 10'({cur_row, 3'b000});
    end
  end

  // Cursor advance after a cursor draw, and saturating cursor set.
  always_comb begin
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    col_inc      = 7'(cur_col) + 7'd1;
    row_inc      = 7'(cur_row);
    if (cmd_acc) begin
      case (cmd.operation)
        OP_DRAW_CURSOR: begin
          if (col_inc >= COLS) begin
            cur_col_next = '0;
            row_inc      = 7'(cur_row) + 7'd1;
          end else begin
            cur_col_next = col_inc[5:0];
          end
          cur_row_next = (row_inc >= ROWS) ? '0 : row_inc[5:0];
        end
        OP_SET_CURSOR: begin
          cur_col_next = (cmd.pos_x > MAX_COL) ? MAX_COL[5:0] : cmd.pos_x[5:0];
          cur_row_next = (cmd.pos_y > MAX_ROW) ? MAX_ROW[5:0] : cmd.pos_y[5:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration and cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_color <= '0;
      cur_col  <= '0;
      cur_row  <= '0;
    end else begin
      if (cfg_we) begin
        bg_color <= cfg_wdata;
      end
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
    end
  end

  // Issue stage control: walk rows 0..6 and columns 0..4 of the glyph.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_row   <= '0;
      s1_col   <= '0;
    end else if (draw) begin
      s1_valid <= 1'b1;
      s1_row   <= '0;
      s1_col   <= '0;
    end else if (s1_valid && advance) begin
      if (s1_end) begin
        s1_valid <= 1'b0;
      end else if (s1_col == LAST_COL) begin
        s1_col <= '0;
        s1_row <= s1_row + 3'd1;
      end else begin
        s1_col <= s1_col + 3'd1;
      end
    end
  end

  // Issue stage payload, captured with the request.
  always_ff @(posedge clk) begin
    if (draw) begin
      s1_base <= glyph_base;
      s1_ox   <= org_x;
      s1_oy   <= org_y;
      s1_ink  <= cmd.ink_color;
    end
  end

  // Font read of the current column byte.
  assign rom_req.en   = s1_valid && advance;
  assign rom_req.addr = s1_base + ROM_AW'(s1_col);

  tgr_glyph_rom u_rom (
    .clk  (clk),
    .req  (rom_req),
    .data (rom_data)
  );

  // Read stage: pixel coordinates travel alongside the font read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_x    <= s1_ox + 10'(s1_col);
      s2_y    <= s1_oy + 10'(s1_row);
      s2_ink  <= s1_ink;
      s2_row  <= s1_row;
      s2_last <= s1_end;
    end
  end

  // Output register: pick ink or background from the font bit of this row.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x     <= s2_x;
      out_y     <= s2_y;
      out_color <= rom_data[s2_row] ? s2_ink : bg_color;
      out_last  <= s2_last;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_x     = out_x;
  assign pix.pixel_y     = out_y;
  assign pix.pixel_color = out_color;
  assign pix.last        = out_last;

endmodule

### hw/rtl/tgr_checker.sv
// Port-level assertions of the glyph renderer and their bind to the top level.
`include "text_glyph_renderer_assert.svh"

module tgr_checker (
  input logic            clk,
  input logic            rst,
  input logic            pix_valid,
  input logic            pix_ready,
  input tgr_pkg::coord_t pix_x,
  input tgr_pkg::coord_t pix_y,
  input tgr_pkg::color_t pix_color,
  input logic            pix_last
);
  import tgr_pkg::*;

  // A stalled pixel stays offered.
  `TGR_ASSERT(a_pix_hold, clk, rst, pix_valid && !pix_ready |=> pix_valid, "pixel dropped while stalled")

  // A stalled pixel keeps its payload.
  `TGR_ASSERT(a_pix_stable, clk, rst, pix_valid && !pix_ready |=> $stable(pix_x) && $stable(pix_y) && $stable(pix_color) && $stable(pix_last), "pixel changed while stalled")

  // Pixels of one character follow without gaps.
  `TGR_ASSERT(a_char_burst, clk, rst, pix_valid && pix_ready && !pix_last |=> pix_valid, "gap inside a character")

  // Reset empties the output.
  `TGR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !pix_valid, "pixel valid after reset")

endmodule

bind text_glyph_renderer tgr_checker u_tgr_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pix_x     (pix.pixel_x),
  .pix_y     (pix.pixel_y),
  .pix_color (pix.pixel_color),
  .pix_last  (pix.last)
);

### verif/glyph_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel predictor and scoreboard for the glyph renderer, fed by the request and pixel channels.
module glyph_pixel_checker #(
  parameter int TEXT_COLUMNS = 40,
  parameter int TEXT_ROWS    = 40
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  tgr_pkg::color_t cfg_wdata,
  tgr_cmd_if              cmd,
  tgr_pix_if              pix,
  output int              pixels_pending,
  output int              error_count
);
  import tgr_pkg::*;

  localparam int CELL_W = 6;
  localparam int CELL_H = 8;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  pixel_t expected_pixels[$];
  color_t background;
  cell_t  cursor_col;
  cell_t  cursor_row;

  // Queue the 35 pixels of one character, row by row, left to right.
  function automatic void render_expected(code_t code, coord_t ox, coord_t oy, color_t ink);
    int         glyph;
    logic [7:0] column_bits;
    pixel_t     p;
    glyph = 0;
    if (code >= FIRST_CODE && code < FIRST_CODE + GLYPH_COUNT) begin
      glyph = int'(code) - int'(FIRST_CODE);
    end
    for (int row = 0; row < GLYPH_H; row++) begin
      for (int col = 0; col < GLYPH_W; col++) begin
        column_bits = GLYPH_ROM[glyph * GLYPH_W + col];
        p.x     = coord_t'(ox + col);
        p.y     = coord_t'(oy + row);
        p.color = column_bits[row] ? ink : background;
        p.last  = (row == GLYPH_H - 1) && (col == GLYPH_W - 1);
        expected_pixels.push_back(p);
      end
    end
  endfunction

  // Step the cursor one cell, wrapping at the end of a line and of the screen.
  function automatic void advance_cursor();
    int next_col;
    int next_row;
    next_col = int'(cursor_col) + 1;
    next_row = int'(cursor_row);
    if (next_col >= TEXT_COLUMNS) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= TEXT_ROWS) begin
      next_row = 0;
    end
    cursor_col = cell_t'(next_col);
    cursor_row = cell_t'(next_row);
  endfunction

  function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Compare each accepted pixel first, then account for the register and any new request.
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      expected_pixels.delete();
      background     = '0;
      cursor_col     = '0;
      cursor_row     = '0;
      error_count    = 0;
      pixels_pending = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        if (expected_pixels.size() == 0) begin
          error_count++;
          $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d color=%0h last=%0b",
                   $time, pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last);
        end else begin
          want = expected_pixels.pop_front();
          compare_field("pixel_x", 16'(want.x), 16'(pix.pixel_x));
          compare_field("pixel_y", 16'(want.y), 16'(pix.pixel_y));
          compare_field("pixel_color", want.color, pix.pixel_color);
          compare_field("last", 16'(want.last), 16'(pix.last));
        end
      end
      if (cfg_we) begin
        background = cfg_wdata;
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.operation)
          OP_DRAW_AT: begin
            render_expected(cmd.char_code, cmd.pos_x, cmd.pos_y, cmd.ink_color);
          end
          OP_DRAW_CURSOR: begin
            render_expected(cmd.char_code, coord_t'(int'(cursor_col) * CELL_W),
                            coord_t'(int'(cursor_row) * CELL_H), cmd.ink_color);
            advance_cursor();
          end
          OP_SET_CURSOR: begin
            cursor_col = (cmd.pos_x > TEXT_COLUMNS - 1) ? cell_t'(TEXT_COLUMNS - 1)
                                                        : cell_t'(cmd.pos_x);
            cursor_row = (cmd.pos_y > TEXT_ROWS - 1) ? cell_t'(TEXT_ROWS - 1)
                                                     : cell_t'(cmd.pos_y);
          end
          default: begin
            // An undefined operation leaves everything untouched.
          end
        endcase
      end
      pixels_pending = expected_pixels.size();
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the glyph renderer: clock, reset, request stimulus, pixel sink and verdict.
module testbench;
  import tgr_pkg::*;

  localparam int  TEXT_COLUMNS    = 40;
  localparam int  TEXT_ROWS       = 40;
  localparam op_t OP_UNDEFINED    = 2'd3;
  localparam int  MAX_GAP         = 5;
  localparam int  MAX_STALL       = 5;
  localparam int  SETTLE_CYCLES   = 8;
  localparam int  RANDOM_PHASES   = 3;
  localparam int  ITEMS_PER_PHASE = 33;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   cfg_we    = 1'b0;
  color_t cfg_wdata = '0;
  int     pixels_pending;
  int     error_count;
  bit     sender_bursts = 1'b0;
  bit     sink_bursts   = 1'b0;

  tgr_cmd_if cmd ();
  tgr_pix_if pix ();

  text_glyph_renderer #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .pix      (pix)
  );

  glyph_pixel_checker #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS)
  ) pixel_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .pix           (pix),
    .pixels_pending(pixels_pending),
    .error_count   (error_count)
  );

  always #4 clk = ~clk;

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_request(op_t op, code_t code, coord_t x, coord_t y, color_t ink);
    int gap;
    @(negedge clk);
    gap = sender_bursts ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.operation <= op;
    cmd.char_code <= code;
    cmd.pos_x     <= x;
    cmd.pos_y     <= y;
    cmd.ink_color <= ink;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted pixel has been seen.
  task automatic wait_for_drain();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (pixels_pending != 0) @(negedge clk);
  endtask

  // A cursor set leaves no pixel behind, so give the block time to settle first.
  task automatic write_background(color_t color);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly printable draws, with cursor moves, odd codes, edge positions and a few undefined ops.
  task automatic send_random_request(output bit counted);
    op_t    op;
    code_t  code;
    coord_t x;
    coord_t y;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      op = OP_DRAW_AT;
    end else if (pick < 80) begin
      op = OP_DRAW_CURSOR;
    end else if (pick < 94) begin
      op = OP_SET_CURSOR;
    end else begin
      op = OP_UNDEFINED;
    end
    code = ($urandom_range(0, 9) == 0) ? code_t'($urandom_range(0, 255))
                                       : code_t'($urandom_range(32, 127));
    if (op == OP_SET_CURSOR && $urandom_range(0, 1) == 0) begin
      x = coord_t'($urandom_range(0, 45));
      y = coord_t'($urandom_range(0, 45));
    end else if ($urandom_range(0, 4) == 0) begin
      x = coord_t'($urandom_range(1015, 1023));
      y = coord_t'($urandom_range(1015, 1023));
    end else begin
      x = coord_t'($urandom_range(0, 1023));
      y = coord_t'($urandom_range(0, 1023));
    end
    send_request(op, code, x, y, color_t'($urandom_range(0, 16'hFFFF)));
    counted = (op != OP_UNDEFINED);
  endtask

  // Pixel sink: a random stall before each pixel, none while sink_bursts is set.
  initial begin : pixel_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      stall = sink_bursts ? 0 : $urandom_range(0, MAX_STALL);
      if (stall > 0) begin
        pix.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pix.ready <= 1'b1;
      @(posedge clk);
      while (!pix.valid) @(posedge clk);
    end
  end

  // Main sequence: reset, directed requests, then random phases under several backgrounds.
  initial begin : stimulus
    int     counted;
    bit     counted_one;
    color_t phase_background;
    cmd.valid     = 1'b0;
    cmd.operation = OP_DRAW_AT;
    cmd.char_code = '0;
    cmd.pos_x     = '0;
    cmd.pos_y     = '0;
    cmd.ink_color = '0;
    pix.ready     = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed requests against a white background.
    write_background(16'hFFFF);
    send_request(OP_DRAW_AT, 8'h41, 10'd0, 10'd0, 16'h0000);
    send_request(OP_DRAW_AT, 8'h30, 10'd10, 10'd20, 16'hF800);
    send_request(OP_DRAW_AT, 8'h7F, 10'd1023, 10'd1023, 16'h07E0);
    send_request(OP_DRAW_AT, 8'h20, 10'd1019, 10'd1017, 16'hFFFF);
    // Codes outside the font draw as a space.
    send_request(OP_DRAW_AT, 8'h1F, 10'd512, 10'd0, 16'h001F);
    send_request(OP_DRAW_AT, 8'h00, 10'd0, 10'd1023, 16'h1234);
    send_request(OP_DRAW_AT, 8'h80, 10'd1023, 10'd0, 16'hABCD);
    send_request(OP_DRAW_AT, 8'hFF, 10'd341, 10'd682, 16'h5555);
    // Cursor set saturates; drawing at the last cell wraps to the top left.
    send_request(OP_SET_CURSOR, 8'h00, 10'd1023, 10'd1023, 16'h0000);
    send_request(OP_DRAW_CURSOR, 8'h23, 10'd0, 10'd0, 16'h0000);
    send_request(OP_DRAW_CURSOR, 8'h61, 10'd1023, 10'd1023, 16'hFFFF);
    // End of a line moves to the next row.
    send_request(OP_SET_CURSOR, 8'hFF, 10'd39, 10'd0, 16'hFFFF);
    send_request(OP_DRAW_CURSOR, 8'h7E, 10'd0, 10'd0, 16'h8410);
    send_request(OP_DRAW_CURSOR, 8'h00, 10'd0, 10'd0, 16'h0001);
    send_request(OP_SET_CURSOR, 8'h41, 10'd40, 10'd40, 16'h0000);
    send_request(OP_DRAW_CURSOR, 8'h5A, 10'd0, 10'd0, 16'h00FF);
    // An undefined operation must not move the cursor or emit pixels.
    send_request(OP_UNDEFINED, 8'h41, 10'd5, 10'd5, 16'h1111);
    send_request(OP_DRAW_CURSOR, 8'hFF, 10'd0, 10'd0, 16'hFFFF);
    send_request(OP_SET_CURSOR, 8'h00, 10'd0, 10'd0, 16'h0000);
    send_request(OP_UNDEFINED, 8'hFF, 10'd1023, 10'd1023, 16'hFFFF);
    send_request(OP_DRAW_CURSOR, 8'h57, 10'd0, 10'd0, 16'hAAAA);

    // Random phases: one with a back-to-back sender, one with a sink that never stalls.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       phase_background = 16'h0000;
        1:       phase_background = color_t'($urandom_range(0, 16'hFFFF));
        default: phase_background = 16'hFFFF;
      endcase
      write_background(phase_background);
      sender_bursts = (phase == 1);
      sink_bursts   = (phase == 2);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 14) == 0) begin
          wait_for_drain();
        end
        send_random_request(counted_one);
        counted += counted_one;
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
